// File: hw/rtl/view_frustum_cull_test_macros.svh
// Assertion helpers for the frustum cull block.
// Both expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef VIEW_FRUSTUM_CULL_TEST_MACROS_SVH
`define VIEW_FRUSTUM_CULL_TEST_MACROS_SVH

// Same-cycle implication.
`define VFCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frustum cull: same-cycle check failed");

// Next-cycle implication.
`define VFCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frustum cull: next-cycle check failed");

`endif

// File: hw/rtl/vfct_pkg.sv
`default_nettype none
package vfct_pkg;

  localparam int unsigned Q_FRAC  = 14;
  localparam int unsigned CRD_W   = 16;
  localparam int unsigned VEC_W   = 3 * CRD_W;
  localparam int unsigned RAD_W   = 15;
  localparam int unsigned OFS_W   = CRD_W + 1;
  localparam int unsigned PROD_W  = OFS_W + CRD_W;
  localparam int unsigned LIM_W   = PROD_W + 3;
  localparam int unsigned NPLANE  = 5;   // view direction plus four side normals
  localparam int unsigned NCORNER = 8;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_POINT  = 2'd0,
    CMD_BOX    = 2'd1,
    CMD_SPHERE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EYE    = 3'd0,
    REG_DIR    = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_LEFT   = 3'd3,
    REG_TOP    = 3'd4,
    REG_BOTTOM = 3'd5,
    REG_NEAR   = 3'd6,
    REG_FAR    = 3'd7
  } cfg_idx_e;

  // Plane 0 is the view direction, 1..4 the side normals.
  typedef struct packed {
    logic [VEC_W-1:0]              eye;
    logic [NPLANE-1:0][VEC_W-1:0]  plane;
    logic [CRD_W-1:0]              near_lim;
    logic [CRD_W-1:0]              far_lim;
  } frustum_cfg_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [2:0][CRD_W-1:0]  a;
    logic [2:0][CRD_W-1:0]  b;
    logic [RAD_W-1:0]       radius;
  } in_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [RAD_W-1:0]       slack;
    logic [2:0][OFS_W-1:0]  ea;
    logic [2:0][OFS_W-1:0]  eb;
  } ofs_t;

  // p[plane][corner side: 0 first, 1 second][axis]
  typedef struct packed {
    logic [1:0]                                cmd;
    logic [RAD_W-1:0]                          slack;
    logic [NPLANE-1:0][1:0][2:0][PROD_W-1:0]   p;
  } prod_t;

endpackage
`default_nettype wire

// File: hw/rtl/vfct_offset.sv
`default_nettype none
module vfct_offset (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  vfct_pkg::in_t             in_i,
  input  logic [vfct_pkg::VEC_W-1:0] eye_i,
  output vfct_pkg::ofs_t            ofs_o
);
  import vfct_pkg::*;

  ofs_t ofs_d, ofs_q;

  // Move both corners into eye space; pick the slack for spheres only.
  always_comb begin
    ofs_d.cmd   = in_i.cmd;
    ofs_d.slack = (in_i.cmd == CMD_SPHERE) ? in_i.radius : '0;
    for (int i = 0; i < 3; i++) begin
      ofs_d.ea[i] = OFS_W'(signed'(OFS_W'($signed(in_i.a[i])))
                  - signed'(OFS_W'($signed(eye_i[i*CRD_W +: CRD_W]))));
      ofs_d.eb[i] = OFS_W'(signed'(OFS_W'($signed(in_i.b[i])))
                  - signed'(OFS_W'($signed(eye_i[i*CRD_W +: CRD_W]))));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ofs_q <= ofs_d;
    end
  end

  assign ofs_o = ofs_q;

endmodule
`default_nettype wire

// File: hw/rtl/vfct_mult.sv
`default_nettype none
module vfct_mult (
  input  logic                                           clk_i,
  input  logic                                           en_i,
  input  vfct_pkg::ofs_t                                 ofs_i,
  input  logic [vfct_pkg::NPLANE-1:0][vfct_pkg::VEC_W-1:0] plane_i,
  output vfct_pkg::prod_t                                prod_o
);
  import vfct_pkg::*;

  prod_t prod_d, prod_q;

  // Per-axis partial products for both box sides; corners reuse them by linearity.
  always_comb begin
    prod_d.cmd   = ofs_i.cmd;
    prod_d.slack = ofs_i.slack;
    for (int p = 0; p < NPLANE; p++) begin
      for (int i = 0; i < 3; i++) begin
        prod_d.p[p][0][i] = PROD_W'(
          signed'(PROD_W'($signed(ofs_i.ea[i])))
          * signed'(PROD_W'($signed(plane_i[p][i*CRD_W +: CRD_W]))));
        prod_d.p[p][1][i] = PROD_W'(
          signed'(PROD_W'($signed(ofs_i.eb[i])))
          * signed'(PROD_W'($signed(plane_i[p][i*CRD_W +: CRD_W]))));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// File: hw/rtl/vfct_judge.sv
`default_nettype none
module vfct_judge (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  vfct_pkg::prod_t            prod_i,
  input  logic [vfct_pkg::CRD_W-1:0] near_i,
  input  logic [vfct_pkg::CRD_W-1:0] far_i,
  output logic                       inside_o
);
  import vfct_pkg::*;

  logic signed [LIM_W-1:0] slack_s;
  logic signed [LIM_W-1:0] near_lo;
  logic signed [LIM_W-1:0] far_hi;
  logic signed [LIM_W-1:0] dot [NCORNER][NPLANE];
  logic [NCORNER-1:0]      pass;
  logic                    inside_d, inside_q;

  always_comb begin
    slack_s = signed'(LIM_W'({prod_i.slack, {Q_FRAC{1'b0}}}));
    near_lo = (signed'(LIM_W'($signed(near_i))) <<< Q_FRAC) - slack_s;
    far_hi  = (signed'(LIM_W'($signed(far_i))) <<< Q_FRAC) + slack_s;
    for (int k = 0; k < NCORNER; k++) begin
      for (int p = 0; p < NPLANE; p++) begin
        dot[k][p] = signed'(LIM_W'($signed(prod_i.p[p][(k >> 0) & 1][0])))
                  + signed'(LIM_W'($signed(prod_i.p[p][(k >> 1) & 1][1])))
                  + signed'(LIM_W'($signed(prod_i.p[p][(k >> 2) & 1][2])));
      end
      pass[k] = (dot[k][0] >= near_lo) && (dot[k][0] <= far_hi)
             && (dot[k][1] <= slack_s) && (dot[k][2] <= slack_s)
             && (dot[k][3] <= slack_s) && (dot[k][4] <= slack_s);
    end
  end

  always_comb begin
    case (prod_i.cmd)
      CMD_POINT:  inside_d = pass[0];
      CMD_SPHERE: inside_d = pass[0];
      CMD_BOX:    inside_d = |pass;
      default:    inside_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_q <= inside_d;
    end
  end

  assign inside_o = inside_q;

endmodule
`default_nettype wire

// File: hw/rtl/view_frustum_cull_test.sv
// View-frustum cull test.
// Input channel (in_valid_i / in_stall_o) carries one word per query: cmd
// selects a point, box or sphere test; first_* is the point, box corner or
// sphere center, second_* the opposite box corner, radius the sphere radius.
// Output channel (out_valid_o / out_stall_i) returns one word per query with
// inside_res_o; results come back in order, one per query.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i selecting eye,
// view direction, right/left/top/bottom normals, near and far. cfg_ready_o
// is always high; write only while no query is in flight.
// Pipeline: input register, eye-space subtract, per-axis multiply, then a
// sum-and-compare stage feeding the result register. A word passes the
// input, offset, product and result registers in order; out_valid_o is
// the valid bit of the last. Throughput is one word per cycle: each of the
// four registers takes a new word every cycle unless the output stalls.
// Each stage loads when it is empty or its word moves on, so bubbles close
// up and the input keeps flowing while a result waits at the output.
// When out_stall_i holds a full pipeline, in_stall_o rises and all stages
// hold. Reset empties the pipeline and loads the registers with an eye at
// the origin, zero direction and normals, near 0 and far 32767.
`default_nettype none
module view_frustum_cull_test (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic signed [15:0]             first_x_i,
  input  logic signed [15:0]             first_y_i,
  input  logic signed [15:0]             first_z_i,
  input  logic signed [15:0]             second_x_i,
  input  logic signed [15:0]             second_y_i,
  input  logic signed [15:0]             second_z_i,
  input  logic [14:0]                    radius_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           inside_res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vfct_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vfct_pkg::VEC_W-1:0]     cfg_data_i
);
  import vfct_pkg::*;

  `include "view_frustum_cull_test_macros.svh"

  frustum_cfg_t cfg_q;
  in_t          in_d, in_q;
  ofs_t         ofs;
  prod_t        prod;

  // Stage valids: 1 input reg, 2 offset, 3 products, 4 result.
  logic v1_q, v2_q, v3_q, v4_q;
  logic ld1, ld2, ld3, ld4;

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, write on valid.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eye      <= '0;
      cfg_q.plane    <= '0;
      cfg_q.near_lim <= '0;
      cfg_q.far_lim  <= CRD_W'(16'sd32767);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_EYE:    cfg_q.eye      <= cfg_data_i;
        REG_DIR:    cfg_q.plane[0] <= cfg_data_i;
        REG_RIGHT:  cfg_q.plane[1] <= cfg_data_i;
        REG_LEFT:   cfg_q.plane[2] <= cfg_data_i;
        REG_TOP:    cfg_q.plane[3] <= cfg_data_i;
        REG_BOTTOM: cfg_q.plane[4] <= cfg_data_i;
        REG_NEAR:   cfg_q.near_lim <= cfg_data_i[CRD_W-1:0];
        REG_FAR:    cfg_q.far_lim  <= cfg_data_i[CRD_W-1:0];
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when empty or when its word advances.
  // ---------------------------------------------------------------------------
  assign ld4 = !v4_q || !out_stall_i;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign in_stall_o  = !ld1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: capture the query word.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_d.cmd    = cmd_i;
    in_d.a[0]   = first_x_i;
    in_d.a[1]   = first_y_i;
    in_d.a[2]   = first_z_i;
    in_d.b[0]   = second_x_i;
    in_d.b[1]   = second_y_i;
    in_d.b[2]   = second_z_i;
    in_d.radius = radius_i;
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      in_q <= in_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath stages.
  // ---------------------------------------------------------------------------
  vfct_offset u_offset (
    .clk_i (clk_i),
    .en_i  (ld2),
    .in_i  (in_q),
    .eye_i (cfg_q.eye),
    .ofs_o (ofs)
  );

  vfct_mult u_mult (
    .clk_i   (clk_i),
    .en_i    (ld3),
    .ofs_i   (ofs),
    .plane_i (cfg_q.plane),
    .prod_o  (prod)
  );

  vfct_judge u_judge (
    .clk_i    (clk_i),
    .en_i     (ld4),
    .prod_i   (prod),
    .near_i   (cfg_q.near_lim),
    .far_i    (cfg_q.far_lim),
    .inside_o (inside_res_o)
  );

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // Input stalls only when every stage is occupied.
  `VFCT_ASSERT_NOW(a_stall_full, in_stall_o, v1_q && v2_q && v3_q && v4_q)
  // A word in the offset stage that advances lands in the product stage.
  `VFCT_ASSERT_NEXT(a_advance, v2_q && ld3, v3_q)
  // A taken result with nothing behind it is not shown again.
  `VFCT_ASSERT_NEXT(a_no_repeat, v4_q && !out_stall_i && !v3_q, !v4_q)

endmodule
`default_nettype wire

// File: dv/view_frustum_cull_test_tb.sv
module view_frustum_cull_test_tb;
  import vfct_pkg::*;

  // Command code that the package leaves unnamed; the block answers it with 0.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Pipeline registers in the block, from input register to result register.
  localparam int PIPE_DEPTH      = 4;
  localparam int IDLE_PCT        = 17;
  localparam int RANDOM_PHASES   = 6;
  localparam int WORDS_PER_PHASE = 142;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] ax, ay, az;
    logic signed [15:0] bx, by, bz;
    logic [14:0]        radius;
  } query_t;

  // Drive every input to a known value from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         cmd_i       = CMD_POINT;
  logic signed [15:0] first_x_i   = '0;
  logic signed [15:0] first_y_i   = '0;
  logic signed [15:0] first_z_i   = '0;
  logic signed [15:0] second_x_i  = '0;
  logic signed [15:0] second_y_i  = '0;
  logic signed [15:0] second_z_i  = '0;
  logic [14:0]        radius_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               inside_res_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  cfg_idx_e           cfg_index_i = REG_EYE;
  logic [VEC_W-1:0]   cfg_data_i  = '0;

  // Shadow copy of the frustum registers, loaded with the reset values.
  logic [VEC_W-1:0] eye_q    = '0;
  logic [VEC_W-1:0] dir_q    = '0;
  logic [VEC_W-1:0] right_q  = '0;
  logic [VEC_W-1:0] left_q   = '0;
  logic [VEC_W-1:0] top_q    = '0;
  logic [VEC_W-1:0] bottom_q = '0;
  logic [CRD_W-1:0] near_q   = '0;
  logic [CRD_W-1:0] far_q    = 16'd32767;

  // Verdicts predicted for accepted queries, oldest first.
  bit verdicts_due[$];
  int fault_count = 0;
  // Set during one whole phase so that neither side idles for a long stretch.
  bit steady_run  = 1'b0;

  view_frustum_cull_test dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .first_z_i    (first_z_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .second_z_i   (second_z_i),
    .radius_i     (radius_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inside_res_o (inside_res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frustum arithmetic
  // ---------------------------------------------------------------------------

  function automatic bit idle_roll();
    return !steady_run && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Signed 16-bit lane k of a packed x,y,z register, widened to 64 bits.
  function automatic longint component_of(logic [VEC_W-1:0] vec, int k);
    logic signed [15:0] c;
    c = vec[16*k +: 16];
    return c;
  endfunction

  // Exact dot product of an eye-space offset with a Q1.14 vector.
  function automatic longint project(longint ex, longint ey, longint ez,
                                     logic [VEC_W-1:0] vec);
    return ex * component_of(vec, 0) + ey * component_of(vec, 1)
         + ez * component_of(vec, 2);
  endfunction

  // Point test with every limit widened by slack; slack 0 gives the plain point test.
  function automatic bit within_frustum(longint x, longint y, longint z, longint slack);
    longint one, ex, ey, ez, s, depth;
    one   = longint'(1) << Q_FRAC;
    ex    = x - component_of(eye_q, 0);
    ey    = y - component_of(eye_q, 1);
    ez    = z - component_of(eye_q, 2);
    s     = slack * one;
    depth = project(ex, ey, ez, dir_q);
    // Equal to a limit counts as inside on every comparison.
    if (depth + s < component_of({32'd0, near_q}, 0) * one) return 1'b0;
    if (depth - s > component_of({32'd0, far_q}, 0) * one) return 1'b0;
    if (project(ex, ey, ez, right_q)  > s) return 1'b0;
    if (project(ex, ey, ez, left_q)   > s) return 1'b0;
    if (project(ex, ey, ez, top_q)    > s) return 1'b0;
    if (project(ex, ey, ez, bottom_q) > s) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit predict_verdict(query_t q);
    bit hit;
    hit = 1'b0;
    case (q.cmd)
      CMD_POINT:  hit = within_frustum(q.ax, q.ay, q.az, 0);
      // Corners only: a box straddling the frustum with all corners out is out.
      // The corners are taken as given, whichever of the two is smaller.
      CMD_BOX: begin
        for (int k = 0; k < NCORNER; k++) begin
          hit |= within_frustum(k[0] ? q.bx : q.ax, k[1] ? q.by : q.ay,
                                k[2] ? q.bz : q.az, 0);
        end
      end
      CMD_SPHERE: hit = within_frustum(q.ax, q.ay, q.az, q.radius);
      default:    hit = 1'b0;
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Query and register traffic
  // ---------------------------------------------------------------------------

  function automatic logic [VEC_W-1:0] pack3(logic signed [15:0] x, logic signed [15:0] y,
                                             logic signed [15:0] z);
    return {z, y, x};
  endfunction

  function automatic query_t build_query(logic [1:0] cmd,
                                         logic signed [15:0] ax, logic signed [15:0] ay,
                                         logic signed [15:0] az, logic signed [15:0] bx,
                                         logic signed [15:0] by, logic signed [15:0] bz,
                                         logic [14:0] radius);
    query_t q;
    q.cmd = cmd;
    q.ax  = ax;
    q.ay  = ay;
    q.az  = az;
    q.bx  = bx;
    q.by  = by;
    q.bz  = bz;
    q.radius = radius;
    return q;
  endfunction

  // Offset within +-spread; spread 0 means any 16-bit value.
  function automatic int scatter(int spread);
    if (spread == 0) return int'($urandom);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic logic signed [15:0] around_eye(int k, int spread);
    return 16'(int'(component_of(eye_q, k)) + scatter(spread));
  endfunction

  // Mostly well-formed queries clustered around the eye so that verdicts split
  // both ways; the widest spread and the unused command add noise.
  function automatic query_t random_query();
    query_t q;
    int     spread;
    int     roll;
    case ($urandom_range(3))
      0:       spread = 64;
      1:       spread = 1024;
      2:       spread = 16384;
      default: spread = 0;
    endcase
    roll = $urandom_range(9);
    if (roll < 3)      q.cmd = CMD_POINT;
    else if (roll < 6) q.cmd = CMD_BOX;
    else if (roll < 9) q.cmd = CMD_SPHERE;
    else               q.cmd = CMD_UNUSED;
    q.ax = around_eye(0, spread);
    q.ay = around_eye(1, spread);
    q.az = around_eye(2, spread);
    if (q.cmd == CMD_BOX) begin
      q.bx = 16'(int'(q.ax) + scatter(spread));
      q.by = 16'(int'(q.ay) + scatter(spread));
      q.bz = 16'(int'(q.az) + scatter(spread));
    end else begin
      // Unused by these commands; randomize to show they are ignored.
      q.bx = 16'($urandom);
      q.by = 16'($urandom);
      q.bz = 16'($urandom);
    end
    if (q.cmd == CMD_SPHERE && spread != 0 && $urandom_range(3) != 0)
      q.radius = 15'($urandom_range(0, spread / 4));
    else
      q.radius = 15'($urandom);
    return q;
  endfunction

  // Present one query word, hold it while stalled, record its verdict on acceptance.
  // Valid stays high afterwards so back-to-back words need no second assignment.
  task automatic send_query(query_t q);
    if (idle_roll()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (idle_roll());
    end
    in_valid_i <= 1'b1;
    cmd_i      <= q.cmd;
    first_x_i  <= q.ax;
    first_y_i  <= q.ay;
    first_z_i  <= q.az;
    second_x_i <= q.bx;
    second_y_i <= q.by;
    second_z_i <= q.bz;
    radius_i   <= q.radius;
    do @(posedge clk_i); while (in_stall_o);
    verdicts_due.push_back(predict_verdict(q));
  endtask

  // Drop valid and hold off until every outstanding verdict has come back,
  // then let the pipeline settle before touching registers.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [VEC_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_EYE:    eye_q    = data;
      REG_DIR:    dir_q    = data;
      REG_RIGHT:  right_q  = data;
      REG_LEFT:   left_q   = data;
      REG_TOP:    top_q    = data;
      REG_BOTTOM: bottom_q = data;
      REG_NEAR:   near_q   = data[CRD_W-1:0];
      REG_FAR:    far_q    = data[CRD_W-1:0];
      default:    ;
    endcase
    // Drop valid between writes so the next write starts in a fresh time step.
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Symmetric frustum looking down +z (or -z when flipped); side normals lean
  // back by tilt, so the half-width at depth z is z * tilt / 16384.
  // Junk in the upper bits of near and far must be dropped by the block.
  task automatic set_frustum(logic signed [15:0] ex, logic signed [15:0] ey,
                             logic signed [15:0] ez, int tilt, bit flip,
                             logic signed [15:0] near_v, logic signed [15:0] far_v);
    logic signed [15:0] fwd;
    logic signed [15:0] lean;
    fwd  = flip ? -16'sd16384 : 16'sd16384;
    lean = flip ? 16'(tilt) : 16'(-tilt);
    drain_results();
    write_register(REG_EYE,    pack3(ex, ey, ez));
    write_register(REG_DIR,    pack3(0, 0, fwd));
    write_register(REG_RIGHT,  pack3(16384, 0, lean));
    write_register(REG_LEFT,   pack3(-16384, 0, lean));
    write_register(REG_TOP,    pack3(0, 16384, lean));
    write_register(REG_BOTTOM, pack3(0, -16384, lean));
    write_register(REG_NEAR,   {32'hA5A5_5A5A, near_v});
    write_register(REG_FAR,    {32'h5A5A_A5A5, far_v});
  endtask

  task automatic random_frustum(bit flip);
    set_frustum(16'(scatter(8000)), 16'(scatter(8000)), 16'(scatter(8000)),
                $urandom_range(1000, 32767), flip,
                16'($urandom_range(0, 100)), 16'($urandom_range(200, 30000)));
  endtask

  // Load all eight registers, either with random words or one fixed word.
  task automatic fill_registers(bit random_fill, logic [VEC_W-1:0] value);
    drain_results();
    for (int i = 0; i < 8; i++)
      write_register(cfg_idx_e'(i), random_fill ? VEC_W'({$urandom, $urandom}) : value);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  // Compare each accepted result word with the oldest verdict, then pick the
  // stall for the next cycle.
  always @(posedge clk_i) begin
    bit want;
    if (out_valid_o && !out_stall_i) begin
      if (verdicts_due.size() == 0) begin
        $error("inside_res: result word with no query outstanding (actual %0b)",
               inside_res_o);
        fault_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (inside_res_o !== want) begin
          $error("inside_res: expected %0b, actual %0b", want, inside_res_o);
          fault_count++;
        end
      end
    end
    out_stall_i <= idle_roll();
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset frustum: zero direction and normals, near 0, far 32767. Every point
  // sits at depth 0 on every plane, so all tests pass. Hit the field extremes.
  task automatic test_reset_config();
    send_query(build_query(CMD_POINT, 32767, 32767, 32767, -32768, -32768, -32768, 15'h7FFF));
    send_query(build_query(CMD_POINT, -32768, -32768, -32768, 32767, 32767, 32767, 15'h0));
    send_query(build_query(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 15'h5555));
    send_query(build_query(CMD_SPHERE, 32767, -32768, 0, 0, 0, 0, 15'h7FFF));
  endtask

  // The unused command answers 0 even for a point that passes.
  task automatic test_unused_command();
    send_query(build_query(CMD_UNUSED, 0, 0, 100, 0, 0, 0, 15'h0));
  endtask

  // Depth and side-plane boundaries, equal counts as inside.
  task automatic test_point_limits();
    set_frustum(0, 0, 0, 8192, 1'b0, 10, 20000);
    send_query(build_query(CMD_POINT, 0, 0, 10, 0, 0, 0, 0));
    send_query(build_query(CMD_POINT, 0, 0, 9, 0, 0, 0, 0));
    send_query(build_query(CMD_POINT, 0, 0, 20000, 0, 0, 0, 0));
    send_query(build_query(CMD_POINT, 0, 0, 20001, 0, 0, 0, 0));
    send_query(build_query(CMD_POINT, 50, 0, 100, 0, 0, 0, 0));
    send_query(build_query(CMD_POINT, 51, 0, 100, 0, 0, 0, 0));
    send_query(build_query(CMD_POINT, -50, 0, 100, 0, 0, 0, 0));
    send_query(build_query(CMD_POINT, 0, 51, 100, 0, 0, 0, 0));
    send_query(build_query(CMD_POINT, 0, -50, 100, 0, 0, 0, 0));
  endtask

  // A straddling box with every corner outside reads as outside; a box given
  // with reversed corners still finds its one inside corner.
  task automatic test_box_corners();
    send_query(build_query(CMD_BOX, -1000, -1000, -5, 1000, 1000, 30000, 0));
    send_query(build_query(CMD_BOX, 30000, 30000, -50, 0, 0, 100, 0));
  endtask

  // The radius widens near, far and side limits by exactly its scaled value.
  task automatic test_sphere_widening();
    send_query(build_query(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 10));
    send_query(build_query(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 9));
    send_query(build_query(CMD_SPHERE, 60, 0, 100, 0, 0, 0, 10));
    send_query(build_query(CMD_SPHERE, 60, 0, 100, 0, 0, 0, 9));
    send_query(build_query(CMD_SPHERE, 0, 0, 20010, 0, 0, 0, 10));
    send_query(build_query(CMD_SPHERE, 0, 0, 20010, 0, 0, 0, 9));
  endtask

  // Widest offsets and products: eye at the minimum corner, extreme components.
  task automatic test_extreme_offsets();
    drain_results();
    write_register(REG_EYE,    pack3(-32768, -32768, -32768));
    write_register(REG_DIR,    pack3(32767, 32767, 32767));
    write_register(REG_RIGHT,  pack3(-32768, -32768, -32768));
    write_register(REG_LEFT,   pack3(-32768, 32767, -32768));
    write_register(REG_TOP,    pack3(32767, -32768, -32768));
    write_register(REG_BOTTOM, pack3(-32768, -32768, 32767));
    write_register(REG_NEAR,   {32'hFFFF_FFFF, 16'h8000});
    write_register(REG_FAR,    {32'h0000_0000, 16'h7FFF});
    send_query(build_query(CMD_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
    send_query(build_query(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    send_query(build_query(CMD_SPHERE, -32768, -32768, -32768, 0, 0, 0, 15'h7FFF));
  endtask

  // Random traffic over several register settings, including all-ones and
  // random words, with one phase free of idling and occasional full drains.
  task automatic test_random_views();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        1:       random_frustum(1'b1);
        2:       fill_registers(1'b1, '0);
        3: begin
          random_frustum(1'b0);
          steady_run = 1'b1;
        end
        4:       fill_registers(1'b0, '1);
        default: random_frustum(1'b0);
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Pause now and then until every verdict is back.
        if (!steady_run && $urandom_range(59) == 0) drain_results();
        send_query(random_query());
      end
      steady_run = 1'b0;
    end
  endtask

  initial begin
    // Hold reset low from time zero, then release it once for the whole run.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_unused_command();
    test_point_limits();
    test_box_corners();
    test_sphere_widening();
    test_extreme_offsets();
    test_random_views();

    drain_results();
    if (fault_count == 0 && verdicts_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/vfct_pkg.sv
hw/rtl/vfct_offset.sv
hw/rtl/vfct_mult.sv
hw/rtl/vfct_judge.sv
hw/rtl/view_frustum_cull_test.sv
dv/view_frustum_cull_test_tb.sv
